[hw/rtl/binary_search_interp_lookup_defines.svh]
// assertion helpers used by binary_search_interp_lookup
// both expect a clock named clk and a synchronous reset named rst in scope
`ifndef BINARY_SEARCH_INTERP_LOOKUP_DEFINES_SVH
`define BINARY_SEARCH_INTERP_LOOKUP_DEFINES_SVH

// condition holds in the same cycle
`define BSIL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define BSIL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bsil_pkg.sv]
`default_nettype none

package bsil_pkg;

  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 7;
  localparam int STEP_W    = 6;
  localparam int TABLE_LEN = 128;
  localparam int DIV_CNT_W = 5;

  // transaction codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // search and interpolation constants
  localparam logic [SLOT_W-1:0] START_SLOT = 7'd64;
  localparam logic [STEP_W-1:0] FIRST_STEP = 6'd32;
  localparam logic [SLOT_W-1:0] SEG_LIMIT  = 7'd99;
  localparam logic [SLOT_W-1:0] LAST_SEG   = 7'd98;
  localparam logic [DATA_W-1:0] FRAC_SCALE = 32'd49;
  localparam logic [DATA_W-1:0] FRAC_MAX   = 32'd48;
  localparam logic [DATA_W-1:0] FAULT_FRAC = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_CMP_HI,
    ST_CMP_LO,
    ST_CLAMP,
    ST_GET_LO,
    ST_GET_HI,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/binary_search_interp_lookup.sv]
// breakpoint table search with linear interpolation
// input channel (in_valid/in_ready): action 0 writes entry_value into slot
//   entry_slot of table table_select; action 1 looks up key in that table
// output channel (out_valid/out_ready): one transaction per lookup with
//   segment_index, fraction in 49ths and divide_fault; writes give none
// a write is accepted whenever the sequencer is idle
// a lookup result is registered after a six-step search on the single
//   ram port (read and compare the upper entry, then the one below it if
//   the key is lower), a clamp, two reads of the segment bounds, a setup
//   state and a wait on the radix-2 divider; the last segment skips all
//   that follows the clamp, and equal bounds or overflow skip the divider
// the sequencer returns to idle as the result is registered, so the next
//   transaction is accepted only after the previous lookup is through
// input is accepted whenever the sequencer is idle, even while a result
//   waits on out_ready; a finished lookup holds in its done state until
//   the output register is free
// reset clears the sequencer and out_valid; table contents are not cleared
//   and must be written before they are searched
// table_select at or above NUM_TABLES wraps modulo NUM_TABLES
`default_nettype none

`include "binary_search_interp_lookup_defines.svh"

module binary_search_interp_lookup import bsil_pkg::*; #(
  parameter int NUM_TABLES = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     action,
  input  wire logic [1:0]               table_select,
  input  wire logic [SLOT_W-1:0]        entry_slot,
  input  wire logic signed [DATA_W-1:0] entry_value,
  input  wire logic signed [DATA_W-1:0] key,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [SLOT_W-1:0]             segment_index,
  output logic signed [DATA_W-1:0]      fraction,
  output logic                          divide_fault
);

  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int DEPTH = NUM_TABLES * TABLE_LEN;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  logic                     in_fire;
  logic                     out_free;
  logic [1:0]               sel_mod;
  logic [TW-1:0]            tbl_in;
  logic [TW-1:0]            tbl;
  logic [TW+SLOT_W-1:0]     addr_full;
  logic [SLOT_W-1:0]        rd_slot;
  logic [AW-1:0]            ram_addr;
  logic                     ram_we;
  logic [DATA_W-1:0]        ram_rdata;

  logic signed [DATA_W-1:0] key_r;
  logic [SLOT_W-1:0]        idx;
  logic [SLOT_W-1:0]        idx_dec;
  logic [SLOT_W-1:0]        seg;
  logic [SLOT_W-1:0]        seg_c;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        step_half;
  logic                     key_ge;
  logic                     key_lt;

  logic [DATA_W-1:0]        low;
  logic [DATA_W-1:0]        diff;
  logic [DATA_W-1:0]        num;
  logic [DATA_W-1:0]        den;
  logic [DATA_W-1:0]        num_mag;
  logic [DATA_W-1:0]        den_mag;
  logic [DATA_W-1:0]        quo;
  logic [DATA_W-1:0]        q_signed;
  logic [DATA_W-1:0]        frac_r;
  logic                     fault_r;
  logic                     neg;
  logic                     ovf_case;
  logic                     div_start;
  div_stat_t                div_stat;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // table number wraps modulo NUM_TABLES (at most three subtractions)
  always_comb begin
    sel_mod = table_select;
    for (int i = 0; i < 3; i++) begin
      if (32'(sel_mod) >= NUM_TABLES) begin
        sel_mod = sel_mod - 2'(NUM_TABLES);
      end
    end
    tbl_in = TW'(sel_mod);
  end

  // search compare and index helpers
  assign idx_dec   = idx - 1'b1;
  assign step_half = step >> 1;
  assign key_ge    = key_r >= $signed(ram_rdata);
  assign key_lt    = key_r < $signed(ram_rdata);
  assign seg_c     = (idx_dec >= SEG_LIMIT) ? LAST_SEG : idx_dec;

  // ram address per state
  always_comb begin
    unique case (state)
      ST_RD_HI:  rd_slot = idx;
      ST_CMP_HI: rd_slot = idx_dec;
      ST_CLAMP:  rd_slot = seg_c;
      ST_GET_LO: rd_slot = seg + 1'b1;
      default:   rd_slot = entry_slot;
    endcase
  end

  assign addr_full = {(state == ST_IDLE) ? tbl_in : tbl, rd_slot};
  assign ram_addr  = addr_full[AW-1:0];
  assign ram_we    = in_fire && (action == ACT_WRITE);

  bsil_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (entry_value),
    .rdata (ram_rdata)
  );

  // divider operands and sign fixup
  assign ovf_case  = (num == FAULT_FRAC) && (den == '1);
  assign num_mag   = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
  assign den_mag   = den[DATA_W-1] ? (DATA_W'(0) - den) : den;
  assign div_start = (state == ST_PREP) && (den != '0) && !ovf_case;
  assign q_signed  = neg ? (DATA_W'(0) - quo) : quo;

  bsil_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den_mag),
    .quotient (quo),
    .stat     (div_stat)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (action == ACT_LOOKUP)) begin
          state_next = ST_RD_HI;
        end
      end
      ST_RD_HI:  state_next = ST_CMP_HI;
      ST_CMP_HI: begin
        if (!key_ge) begin
          state_next = ST_CMP_LO;
        end else if (step_half == '0) begin
          state_next = ST_CLAMP;
        end else begin
          state_next = ST_RD_HI;
        end
      end
      ST_CMP_LO: begin
        if (key_lt && (step_half != '0)) begin
          state_next = ST_RD_HI;
        end else begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP:  state_next = (seg_c == LAST_SEG) ? ST_DONE : ST_GET_LO;
      ST_GET_LO: state_next = ST_GET_HI;
      ST_GET_HI: state_next = ST_PREP;
      ST_PREP:   state_next = div_start ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (action == ACT_LOOKUP)) begin
          key_r <= key;
          tbl   <= tbl_in;
          idx   <= START_SLOT;
          step  <= FIRST_STEP;
        end
      end
      ST_CMP_HI: begin
        if (key_ge) begin
          idx  <= idx + SLOT_W'(step);
          step <= step_half;
        end
      end
      ST_CMP_LO: begin
        if (key_lt) begin
          idx  <= idx - SLOT_W'(step);
          step <= step_half;
        end
      end
      ST_CLAMP: begin
        seg     <= seg_c;
        frac_r  <= FRAC_MAX;
        fault_r <= 1'b0;
      end
      ST_GET_LO: begin
        low  <= ram_rdata;
        diff <= key_r - ram_rdata;
      end
      ST_GET_HI: begin
        den <= ram_rdata - low;
        num <= diff * FRAC_SCALE;
      end
      ST_PREP: begin
        neg <= num[DATA_W-1] ^ den[DATA_W-1];
        if (den == '0) begin
          frac_r <= '0;
        end else if (ovf_case) begin
          frac_r  <= FAULT_FRAC;
          fault_r <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (!q_signed[DATA_W-1] && (q_signed > FRAC_MAX)) begin
            frac_r <= FRAC_MAX;
          end else begin
            frac_r <= q_signed;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      segment_index <= seg;
      fraction      <= frac_r;
      divide_fault  <= fault_r;
    end
  end

  `BSIL_ASSERT_IMP(a_seg_range, out_valid, segment_index <= LAST_SEG, "segment index above 98")
  `BSIL_ASSERT_IMP(a_fault_frac, out_valid && divide_fault, fraction == FAULT_FRAC, "fault without wrapped quotient")
  `BSIL_ASSERT_IMP(a_frac_max, out_valid && !divide_fault, fraction <= $signed(FRAC_MAX), "fraction not clamped")
  `BSIL_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `BSIL_ASSERT_IMP(a_div_done_state, div_stat.done, state == ST_DIV, "divider finished outside wait state")
  `BSIL_ASSERT_NXT(a_last_seg, (state == ST_CLAMP) && (seg_c == LAST_SEG), (frac_r == FRAC_MAX) && !fault_r, "last segment fraction wrong")

endmodule

`default_nettype wire

[hw/rtl/bsil_ram.sv]
`default_nettype none

module bsil_ram import bsil_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hw/rtl/bsil_div.sv]
`default_nettype none

module bsil_div import bsil_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic      [DATA_W-1:0] quotient,
  output div_stat_t              stat
);

  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W+1:0]    trial;

  // one restoring step per cycle
  assign shifted = {rem, quotient[DATA_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (stat.busy) begin
      if (trial[DATA_W+1]) begin
        rem      <= shifted[DATA_W-1:0];
        quotient <= {quotient[DATA_W-2:0], 1'b0};
      end else begin
        rem      <= trial[DATA_W-1:0];
        quotient <= {quotient[DATA_W-2:0], 1'b1};
      end
    end
  end

endmodule

`default_nettype wire
